### rtl/sau_pkg.sv
// shared types and constants of the stack arithmetic unit
package sau_pkg;

  // default sizes
  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned DATA_WIDTH_DEF  = 32;

  // fixed field widths
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned STATUS_W = 2;

  // instruction codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH = 3'd0,
    ACT_POP  = 3'd1,
    ACT_SWAP = 3'd2,
    ACT_ADD  = 3'd3,
    ACT_SUB  = 3'd4,
    ACT_MUL  = 3'd5
  } action_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

### rtl/stack_arithmetic_unit_top.sv
// stack arithmetic unit: stack memory, top-of-stack register, iterative multiplier
// from accepted word to result in the output register: push, pop to empty, errors
// and unknown codes go there directly; pop, swap, add, sub pass S_READ (one memory
// read); mul passes S_READ, then four S_MUL steps of one half-width multiplier
// a new instruction is taken only in S_IDLE with the output register free or read;
// the single read port of the stack memory and the shared multiplier set this limit
// reset: synchronous active-low rst_n empties the stack; memory contents stay unset
module stack_arithmetic_unit_top #(
  parameter int unsigned STACK_DEPTH = sau_pkg::STACK_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH  = sau_pkg::DATA_WIDTH_DEF,
  localparam int unsigned CW          = $clog2(STACK_DEPTH + 1),
  localparam int unsigned IN_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_TDATA_W = ((DATA_WIDTH + CW + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // instruction channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [IN_TDATA_W-1:0]         in_tdata,   // push_value
  input  logic [sau_pkg::ACTION_W-1:0]  in_tuser,   // action
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_TDATA_W-1:0]        out_tdata,  // top_value, stack_depth
  output logic [sau_pkg::STATUS_W-1:0]  out_tuser   // status
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned H  = (DATA_WIDTH + 1) / 2;
  localparam int unsigned W2 = 2 * H;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_MUL  = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [DATA_WIDTH-1:0]   top_r, top_nxt;
  sau_pkg::action_t        op_r, op_nxt;
  logic [DATA_WIDTH-1:0]   a_r, a_nxt;
  logic [1:0]              step_r, step_nxt;
  logic [W2-1:0]           acc_r, acc_nxt;
  logic [W2-1:0]           prod_r, prod_nxt;
  logic [H-1:0]            mul_x, mul_y;
  logic [W2-1:0]           a_ext, b_ext, prod_sh;

  // stack memory below the top entry
  logic [DATA_WIDTH-1:0]   mem [STACK_DEPTH];
  logic [DATA_WIDTH-1:0]   rdata_r;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0]   mem_wdata;

  // output register
  logic                    out_valid_r;
  sau_pkg::status_t        out_status_r;
  logic [DATA_WIDTH-1:0]   out_top_r;
  logic [CW-1:0]           out_depth_r;

  logic                    in_acc;
  sau_pkg::action_t        in_act;
  logic                    done;
  sau_pkg::status_t        res_status;
  logic [CW-1:0]           cnt_m1, cnt_m2;

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;
  assign in_act    = sau_pkg::action_t'(in_tuser);
  assign cnt_m1    = count_r - CW'(1);
  assign cnt_m2    = count_r - CW'(2);

  // multiplier operands per step: lo*lo, lo*hi, hi*lo
  assign a_ext   = W2'(a_r);
  assign b_ext   = W2'(top_r);
  assign prod_sh = {prod_r[H-1:0], {H{1'b0}}};

  always_comb begin
    case (step_r)
      2'd0: begin
        mul_x = a_ext[H-1:0];
        mul_y = b_ext[H-1:0];
      end
      2'd1: begin
        mul_x = a_ext[H-1:0];
        mul_y = b_ext[W2-1:H];
      end
      2'd2: begin
        mul_x = a_ext[W2-1:H];
        mul_y = b_ext[H-1:0];
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
    prod_nxt = W2'(mul_x) * W2'(mul_y);
  end

  // instruction sequencer
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    top_nxt    = top_r;
    op_nxt     = op_r;
    a_nxt      = a_r;
    step_nxt   = step_r;
    acc_nxt    = acc_r;
    mem_we     = 1'b0;
    mem_waddr  = cnt_m1[AW-1:0];
    mem_wdata  = top_r;
    mem_raddr  = cnt_m2[AW-1:0];
    done       = 1'b0;
    res_status = sau_pkg::ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt = in_act;
          case (in_act)
            sau_pkg::ACT_PUSH: begin
              done = 1'b1;
              if (count_r == CW'(STACK_DEPTH)) begin
                res_status = sau_pkg::ST_FULL;
              end else begin
                mem_we    = (count_r != '0);
                top_nxt   = in_tdata[DATA_WIDTH-1:0];
                count_nxt = count_r + CW'(1);
              end
            end
            sau_pkg::ACT_POP: begin
              if (count_r == '0) begin
                res_status = sau_pkg::ST_SHORT;
                done       = 1'b1;
              end else if (count_r == CW'(1)) begin
                count_nxt = '0;
                top_nxt   = '0;
                done      = 1'b1;
              end else begin
                state_nxt = S_READ;
              end
            end
            sau_pkg::ACT_SWAP, sau_pkg::ACT_ADD, sau_pkg::ACT_SUB, sau_pkg::ACT_MUL: begin
              if (count_r < CW'(2)) begin
                res_status = sau_pkg::ST_SHORT;
                done       = 1'b1;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
        done      = 1'b1;
        case (op_r)
          sau_pkg::ACT_POP: begin
            top_nxt   = rdata_r;
            count_nxt = cnt_m1;
          end
          sau_pkg::ACT_SWAP: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_m2[AW-1:0];
            top_nxt   = rdata_r;
          end
          sau_pkg::ACT_ADD: begin
            top_nxt   = rdata_r + top_r;
            count_nxt = cnt_m1;
          end
          sau_pkg::ACT_SUB: begin
            top_nxt   = rdata_r - top_r;
            count_nxt = cnt_m1;
          end
          sau_pkg::ACT_MUL: begin
            a_nxt     = rdata_r;
            step_nxt  = 2'd0;
            done      = 1'b0;
            state_nxt = S_MUL;
          end
          default: begin
          end
        endcase
      end
      S_MUL: begin
        step_nxt = step_r + 2'd1;
        case (step_r)
          2'd0: acc_nxt = '0;
          2'd1: acc_nxt = prod_r;
          2'd2: acc_nxt = acc_r + prod_sh;
          default: begin
            acc_nxt   = acc_r + prod_sh;
            top_nxt   = acc_nxt[DATA_WIDTH-1:0];
            count_nxt = cnt_m1;
            done      = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      step_r  <= step_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    top_r  <= top_nxt;
    op_r   <= op_nxt;
    a_r    <= a_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    if (done) begin
      out_status_r <= res_status;
      out_top_r    <= (count_nxt == '0) ? '0 : top_nxt;
      out_depth_r  <= count_nxt;
    end
  end

  // stack memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_depth_r, out_top_r});
  assign out_tuser  = out_status_r;

endmodule

### rtl/sau_checker.sv
// port checker for the stack arithmetic unit, bound to the top level
module sau_checker #(
  parameter int unsigned STACK_DEPTH = sau_pkg::STACK_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH  = sau_pkg::DATA_WIDTH_DEF,
  localparam int unsigned CW          = $clog2(STACK_DEPTH + 1),
  localparam int unsigned IN_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_TDATA_W = ((DATA_WIDTH + CW + 7) / 8) * 8
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [IN_TDATA_W-1:0]         in_tdata,
  input logic [sau_pkg::ACTION_W-1:0]  in_tuser,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [OUT_TDATA_W-1:0]        out_tdata,
  input logic [sau_pkg::STATUS_W-1:0]  out_tuser
);

  logic [CW-1:0]         depth;
  logic [DATA_WIDTH-1:0] top;

  assign depth = out_tdata[DATA_WIDTH +: CW];
  assign top   = out_tdata[DATA_WIDTH-1:0];

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // no new word taken while a result is stalled
  a_no_accept_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while result stalled");

  // depth never exceeds the stack size
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> depth <= CW'(STACK_DEPTH))
    else $error("depth beyond stack size");

  // full status only with a full stack
  a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == sau_pkg::ST_FULL |-> depth == CW'(STACK_DEPTH))
    else $error("full status with room left");

  // empty stack shows zero on top
  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && depth == '0 |-> top == '0)
    else $error("nonzero top on empty stack");

endmodule

bind stack_arithmetic_unit_top sau_checker #(
  .STACK_DEPTH(STACK_DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_sau_checker (.*);
